[rtl/core/itf_pkg.sv]
// ---------------------------------------------------------------------------
// itf_pkg
// Shared constants, register indexes and helpers for the integer text
// formatter.
// ---------------------------------------------------------------------------
package itf_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int MAX_CHARS      = 64;
   localparam int STORE_DEPTH    = 64;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int CNT_BITS       = $clog2(MAX_CHARS) + 1;
   localparam int CHAR_BITS      = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE_SELECT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_CASE   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_DIGITS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FIELD_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_FILL    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEFT_JUSTIFY = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPACE_POS    = 3'd6;

   localparam logic [1:0] BASE_BIN = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_DEC = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER = 8'h57;  // 'a' - 10
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 8'h37;  // 'A' - 10
   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;

   // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
   localparam logic [VALUE_BITS-1:0] DEC_RECIP = 32'hCCCC_CCCD;
   localparam int                    DEC_SHIFT = 35;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d,
                                                       input logic       upper);
      logic [CHAR_BITS-1:0] base_ch;
      if (d > 4'd9) begin
         base_ch = upper ? CHAR_UPPER : CHAR_LOWER;
      end else begin
         base_ch = CHAR_ZERO;
      end
      return base_ch + {4'd0, d};
   endfunction

endpackage

[rtl/core/integer_to_text_formatter.sv]
// ---------------------------------------------------------------------------
// integer_to_text_formatter
// printf-style integer formatter: sign, radix digits, precision and padding,
// one ASCII character per response strobe.
// Steps: one digit step per digit (a divide step and a write step in decimal),
//   a finish step, a layout step, then characters at one per cycle.
// A text holds at most 64 characters; an empty text gives a single NUL
//   character flagged empty and last.
// A new request is taken only once the last character has been shown.
// Synchronous reset restores register defaults and idles control; the
//   digit RAM is not cleared.
// ---------------------------------------------------------------------------
module integer_to_text_formatter
   import itf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [VALUE_BITS-1:0]     req_value,
   input  logic                      req_is_signed,
   output logic                      rsp_valid,
   output logic [CHAR_BITS-1:0]      rsp_character,
   output logic                      rsp_empty_res,
   output logic                      rsp_last,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIG,
      S_DEC,
      S_PLAN,
      S_EMIT
   } state_type;

   // configuration
   logic [1:0]          base_ff;
   logic                upper_ff;
   logic [5:0]          min_digits_ff;
   logic [5:0]          field_width_ff;
   logic                zero_fill_ff;
   logic                left_justify_ff;
   logic                space_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff         <= BASE_DEC;
         upper_ff        <= 1'b0;
         min_digits_ff   <= 6'd1;
         field_width_ff  <= 6'd1;
         zero_fill_ff    <= 1'b0;
         left_justify_ff <= 1'b0;
         space_pos_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_BASE_SELECT:  base_ff         <= csr_wdata[1:0];
            REG_UPPER_CASE:   upper_ff        <= csr_wdata[0];
            REG_MIN_DIGITS:   min_digits_ff   <= csr_wdata;
            REG_FIELD_WIDTH:  field_width_ff  <= csr_wdata;
            REG_ZERO_FILL:    zero_fill_ff    <= csr_wdata[0];
            REG_LEFT_JUSTIFY: left_justify_ff <= csr_wdata[0];
            REG_SPACE_POS:    space_pos_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // datapath and control state
   state_type            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic                 neg_ff, neg_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic [CNT_BITS-1:0]  b1_ff, b1_in;
   logic [CNT_BITS-1:0]  b2_ff, b2_in;
   logic [CNT_BITS-1:0]  b3_ff, b3_in;
   logic [CNT_BITS-1:0]  b4_ff, b4_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;
   logic [CHAR_BITS-1:0] sign_ch_ff, sign_ch_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0] out_char_ff, out_char_in;
   logic                 out_ram_ff, out_ram_in;
   logic                 out_empty_ff, out_empty_in;
   logic                 out_last_ff, out_last_in;

   // digit RAM
   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic [CHAR_BITS-1:0] ram_wdata;
   logic [ADDR_BITS-1:0] ram_raddr;
   logic [CHAR_BITS-1:0] ram_rdata;

   itf_ram #(
      .WIDTH(CHAR_BITS),
      .DEPTH(STORE_DEPTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic [2*VALUE_BITS-1:0] dec_prod;
   logic [VALUE_BITS-1:0]   dec_rem;
   logic [VALUE_BITS-1:0]   start_mag;
   logic                    start_neg;
   logic [CNT_BITS-1:0]     sign_len;
   logic [CNT_BITS-1:0]     lead_zeros;
   logic [CNT_BITS-1:0]     content;
   logic [CNT_BITS-1:0]     pad;
   logic [CNT_BITS-1:0]     md_ext;
   logic [CNT_BITS-1:0]     fw_ext;
   logic [CNT_BITS-1:0]     rd_index;

   assign dec_prod  = mag_ff * DEC_RECIP;
   assign dec_rem   = mag_ff - {quot_ff[VALUE_BITS-4:0], 3'b000}
                             - {quot_ff[VALUE_BITS-2:0], 1'b0};
   assign start_neg = req_is_signed & req_value[VALUE_BITS-1];
   assign start_mag = start_neg ? (~req_value + 1'b1) : req_value;
   assign md_ext    = {1'b0, min_digits_ff};
   assign fw_ext    = {1'b0, field_width_ff};
   assign sign_len  = {{(CNT_BITS-1){1'b0}}, (neg_ff | space_pos_ff)};
   assign lead_zeros = (md_ext > count_ff) ? (md_ext - count_ff) : '0;
   assign content   = sign_len + count_ff + lead_zeros;
   assign pad       = (fw_ext > content) ? (fw_ext - content) : '0;
   assign rd_index  = b4_ff - pos_ff - 1'b1;
   assign ram_raddr = rd_index[ADDR_BITS-1:0];
   assign ram_waddr = count_ff[ADDR_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      quot_in      = quot_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      total_in     = total_ff;
      sign_ch_in   = sign_ch_ff;
      out_valid_in = 1'b0;
      out_char_in  = out_char_ff;
      out_ram_in   = 1'b0;
      out_empty_in = 1'b0;
      out_last_in  = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = digit_char(mag_ff[3:0], upper_ff);

      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               if (start_mag == '0 && min_digits_ff == '0) begin
                  out_valid_in = 1'b1;
                  out_char_in  = CHAR_NUL;
                  out_empty_in = 1'b1;
                  out_last_in  = 1'b1;
               end else begin
                  mag_in   = start_mag;
                  neg_in   = start_neg;
                  count_in = '0;
                  state_in = S_DIG;
               end
            end
         end
         S_DIG: begin
            if (mag_ff == '0) begin
               state_in = S_PLAN;
            end else begin
               case (base_ff)
                  BASE_BIN: begin
                     ram_we    = 1'b1;
                     ram_wdata = digit_char({3'b000, mag_ff[0]}, upper_ff);
                     mag_in    = mag_ff >> 1;
                     count_in  = count_ff + 1'b1;
                  end
                  BASE_OCT: begin
                     ram_we    = 1'b1;
                     ram_wdata = digit_char({1'b0, mag_ff[2:0]}, upper_ff);
                     mag_in    = mag_ff >> 3;
                     count_in  = count_ff + 1'b1;
                  end
                  BASE_HEX: begin
                     ram_we    = 1'b1;
                     ram_wdata = digit_char(mag_ff[3:0], upper_ff);
                     mag_in    = mag_ff >> 4;
                     count_in  = count_ff + 1'b1;
                  end
                  default: begin
                     quot_in  = dec_prod[2*VALUE_BITS-1:DEC_SHIFT] == '0 ? '0 :
                                {{(DEC_SHIFT-VALUE_BITS){1'b0}},
                                 dec_prod[2*VALUE_BITS-1:DEC_SHIFT]};
                     state_in = S_DEC;
                  end
               endcase
            end
         end
         S_DEC: begin
            ram_we    = 1'b1;
            ram_wdata = digit_char(dec_rem[3:0], upper_ff);
            mag_in    = quot_ff;
            count_in  = count_ff + 1'b1;
            state_in  = S_DIG;
         end
         S_PLAN: begin
            b1_in      = (!left_justify_ff && !zero_fill_ff) ? pad : '0;
            b2_in      = ((!left_justify_ff && !zero_fill_ff) ? pad : '0) + sign_len;
            b3_in      = ((!left_justify_ff) ? pad : '0) + sign_len + lead_zeros;
            b4_in      = ((!left_justify_ff) ? pad : '0) + content;
            total_in   = content + pad;
            sign_ch_in = neg_ff ? CHAR_MINUS : CHAR_SPACE;
            pos_in     = '0;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            out_valid_in = 1'b1;
            out_last_in  = (pos_ff == total_ff - 1'b1);
            if (pos_ff < b1_ff) begin
               out_char_in = CHAR_SPACE;
            end else if (pos_ff < b2_ff) begin
               out_char_in = sign_ch_ff;
            end else if (pos_ff < b3_ff) begin
               out_char_in = CHAR_ZERO;
            end else if (pos_ff < b4_ff) begin
               out_ram_in = 1'b1;
            end else begin
               out_char_in = CHAR_SPACE;
            end
            pos_in = pos_ff + 1'b1;
            if (out_last_in) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_ram_ff   <= 1'b0;
         out_empty_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
         out_ram_ff   <= out_ram_in;
         out_empty_ff <= out_empty_in;
         out_last_ff  <= out_last_in;
      end
      mag_ff      <= mag_in;
      quot_ff     <= quot_in;
      neg_ff      <= neg_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      total_ff    <= total_in;
      sign_ch_ff  <= sign_ch_in;
      out_char_ff <= out_char_in;
   end

   assign busy          = (state_ff != S_IDLE) || out_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_ram_ff ? ram_rdata : out_char_ff;
   assign rsp_empty_res = out_valid_ff & out_empty_ff;
   assign rsp_last      = out_valid_ff & out_last_ff;

endmodule

[rtl/core/itf_ram.sv]
// ---------------------------------------------------------------------------
// itf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module itf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/itf_checker.sv]
// ---------------------------------------------------------------------------
// itf_checker
// Port-level checks on the integer text formatter, bound to the top level.
// ---------------------------------------------------------------------------
module itf_checker
   import itf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [CHAR_BITS-1:0] rsp_character,
   input logic                 rsp_empty_res,
   input logic                 rsp_last
);

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty response without last");

   a_empty_is_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_character == CHAR_NUL)
      else $error("empty response with nonzero character");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but busy stayed low");

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while not busy");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("response strobe right after last");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_empty_res (rsp_empty_res),
   .rsp_last      (rsp_last)
);
